// ===== hw/rtl/randomized_prim_maze_generator_macros.svh =====
// Assertion macros for the Prim maze carver.
// Used by the top level only; no dependencies.
`ifndef RANDOMIZED_PRIM_MAZE_GENERATOR_MACROS_SVH
`define RANDOMIZED_PRIM_MAZE_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
`define RPMG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RPMG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RPMG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RPMG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/rpmg_pkg.sv =====
// Shared types and codes for the Prim maze carver.
// No dependencies.
`default_nettype none
package rpmg_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MOD,
    ST_FR_RD_PICK,
    ST_FR_RD_LAST,
    ST_MARK,
    ST_NBR_RD,
    ST_NBR_WR,
    ST_FIN
  } state_t;

  // request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  // configuration register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // neighbour directions
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // mark memory entry: {in_maze, visited}
  localparam logic [1:0] MK_CLEAR   = 2'b00;
  localparam logic [1:0] MK_VISITED = 2'b01;
  localparam logic [1:0] MK_IN_MAZE = 2'b11;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rpmg_mod.sv =====
// Bit-serial modulo unit: 32-bit dividend modulo a frontier count.
// Depends on rpmg_pkg (mod_stat_t).
`default_nettype none
module rpmg_mod #(
  parameter int NW = 13
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               go,
  input  wire logic [31:0]        dividend,
  input  wire logic [NW-1:0]      divisor,
  output rpmg_pkg::mod_stat_t     stat,
  output logic      [NW-1:0]      rem
);
  import rpmg_pkg::*;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [31:0]   dvd_r, dvd_nxt;
  logic [NW-1:0] dsr_r, dsr_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW:0]   trial;

  // one restoring step per cycle, dividend MSB first
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[31]};
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        trial = trial - {1'b0, dsr_r};
      end
      rem_nxt = trial[NW-1:0];
      dvd_nxt = {dvd_r[30:0], 1'b0};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;

endmodule
`default_nettype wire

// ===== hw/rtl/randomized_prim_maze_generator.sv =====
// Prim maze carver. A step runs the modulo, the frontier swap, the cell mark, a read and
// a write per in-grid neighbour and one check per off-grid neighbour, then posts.
// An empty-frontier step goes straight to the post. Start: a sweep over the mark memory of
// 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) entries, then cell (0,0) is marked, neighbours pushed.
// One item at a time; the next is taken while a result waits.
// Reset (synchronous, rst_n low): idle, frontier empty, grid 64 x 64.
`default_nettype none
`include "randomized_prim_maze_generator_macros.svh"
module randomized_prim_maze_generator #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [31:0] in_random_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       out_cell_row,
  output logic [5:0]       out_cell_col,
  output logic             out_carved,
  output logic [1:0]       out_carve_dir,
  output logic [12:0]      out_frontier_left,
  output logic             out_maze_done,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_wdata
);
  import rpmg_pkg::*;

  localparam int NCELLS = MAX_ROWS * MAX_COLS;
  localparam int RW     = $clog2(MAX_ROWS);
  localparam int CLW    = $clog2(MAX_COLS);
  localparam int AW     = RW + CLW;
  localparam int MD     = 1 << AW;
  localparam int CW     = $clog2(NCELLS);
  localparam int NW     = $clog2(NCELLS + 1);
  localparam int DW     = 12;
  localparam logic [DW-1:0] MAXR = DW'(MAX_ROWS);
  localparam logic [DW-1:0] MAXC = DW'(MAX_COLS);

  state_t          state_r, state_nxt;
  logic [6:0]      rows_r, cols_r;
  logic [NW-1:0]   count_r, count_nxt, cnt_m1;
  logic [NW-1:0]   pick_r, pick_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [CLW-1:0]  col_r, col_nxt;
  logic            carved_r, carved_nxt;
  logic [1:0]      dir_r, dir_nxt;
  logic            done_r, done_nxt;
  logic [1:0]      k_r, k_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;

  logic            in_xfer, out_xfer, out_free;

  // mark memory
  logic [1:0]      mk_mem [MD];
  logic            mk_we, mk_re;
  logic [AW-1:0]   mk_wa, mk_ra;
  logic [1:0]      mk_wd, mk_rd_r;

  // frontier memory
  logic [AW-1:0]   fr_mem [NCELLS];
  logic            fr_we, fr_re;
  logic [CW-1:0]   fr_wa, fr_ra;
  logic [AW-1:0]   fr_wd, fr_rd_r;

  logic            mod_go;
  mod_stat_t       mod_st;
  logic [NW-1:0]   mod_rem;

  // neighbour of the current cell
  logic [DW-1:0]   rows_eff, cols_eff, r_ext, c_ext;
  logic            nb_ok;
  logic [RW-1:0]   nb_row;
  logic [CLW-1:0]  nb_col;

  logic            out_valid_r;
  logic [5:0]      out_row_r, out_col_r;
  logic            out_carved_r, out_done_r;
  logic [1:0]      out_dir_r;
  logic [12:0]     out_left_r;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign cnt_m1   = count_r - 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 7'd64;
      cols_r <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS: rows_r <= cfg_wdata;
        REG_COLS: cols_r <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // clamp grid size to 1..MAX
  always_comb begin
    rows_eff = DW'(rows_r);
    cols_eff = DW'(cols_r);
    if (rows_r == 7'd0) rows_eff = DW'(1);
    else if (rows_eff > MAXR) rows_eff = MAXR;
    if (cols_r == 7'd0) cols_eff = DW'(1);
    else if (cols_eff > MAXC) cols_eff = MAXC;
  end

  // neighbour in direction k
  always_comb begin
    r_ext  = DW'(row_r);
    c_ext  = DW'(col_r);
    nb_row = row_r;
    nb_col = col_r;
    nb_ok  = 1'b0;
    unique case (k_r)
      DIR_UP: begin
        nb_row = row_r - 1'b1;
        nb_ok  = (row_r != '0) && (r_ext - 1'b1 < rows_eff) && (c_ext < cols_eff);
      end
      DIR_DOWN: begin
        nb_row = row_r + 1'b1;
        nb_ok  = (r_ext + 1'b1 < rows_eff) && (c_ext < cols_eff);
      end
      DIR_LEFT: begin
        nb_col = col_r - 1'b1;
        nb_ok  = (col_r != '0) && (c_ext - 1'b1 < cols_eff) && (r_ext < rows_eff);
      end
      DIR_RIGHT: begin
        nb_col = col_r + 1'b1;
        nb_ok  = (c_ext + 1'b1 < cols_eff) && (r_ext < rows_eff);
      end
      default: ;
    endcase
  end

  rpmg_mod #(.NW(NW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (mod_go),
    .dividend (in_random_word),
    .divisor  (count_r),
    .stat     (mod_st),
    .rem      (mod_rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_req_type == REQ_START) state_nxt = ST_CLEAR;
          else if (count_r == '0) state_nxt = ST_FIN;
          else state_nxt = ST_MOD;
        end
      end
      ST_CLEAR:      if (clr_r == AW'(MD - 1)) state_nxt = ST_MARK;
      ST_MOD:        if (mod_st.done) state_nxt = ST_FR_RD_PICK;
      ST_FR_RD_PICK: state_nxt = ST_FR_RD_LAST;
      ST_FR_RD_LAST: state_nxt = ST_MARK;
      ST_MARK:       state_nxt = ST_NBR_RD;
      ST_NBR_RD: begin
        if (nb_ok) state_nxt = ST_NBR_WR;
        else if (k_r == DIR_RIGHT) state_nxt = ST_FIN;
      end
      ST_NBR_WR:     state_nxt = (k_r == DIR_RIGHT) ? ST_FIN : ST_NBR_RD;
      ST_FIN:        if (out_free) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    count_nxt  = count_r;
    pick_nxt   = pick_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    carved_nxt = carved_r;
    dir_nxt    = dir_r;
    done_nxt   = done_r;
    k_nxt      = k_r;
    clr_nxt    = clr_r;
    mod_go     = 1'b0;
    mk_we      = 1'b0;
    mk_wa      = {row_r, col_r};
    mk_wd      = MK_CLEAR;
    mk_re      = 1'b0;
    mk_ra      = {nb_row, nb_col};
    fr_we      = 1'b0;
    fr_wa      = count_r[CW-1:0];
    fr_wd      = {nb_row, nb_col};
    fr_re      = 1'b0;
    fr_ra      = mod_rem[CW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          carved_nxt = 1'b0;
          dir_nxt    = DIR_UP;
          done_nxt   = 1'b0;
          clr_nxt    = '0;
          if (in_req_type == REQ_STEP) begin
            if (count_r == '0) begin
              done_nxt = 1'b1;
              row_nxt  = '0;
              col_nxt  = '0;
            end else begin
              mod_go = 1'b1;
            end
          end
        end
      end
      ST_CLEAR: begin
        // wipe all marks, then seed cell (0,0)
        mk_we   = 1'b1;
        mk_wa   = clr_r;
        mk_wd   = MK_CLEAR;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(MD - 1)) begin
          count_nxt = '0;
          row_nxt   = '0;
          col_nxt   = '0;
        end
      end
      ST_MOD: begin
        if (mod_st.done) begin
          pick_nxt = mod_rem;
          fr_re    = 1'b1;
          fr_ra    = mod_rem[CW-1:0];
        end
      end
      ST_FR_RD_PICK: begin
        // take picked cell, fetch last entry
        row_nxt = fr_rd_r[AW-1:CLW];
        col_nxt = fr_rd_r[CLW-1:0];
        fr_re   = 1'b1;
        fr_ra   = cnt_m1[CW-1:0];
      end
      ST_FR_RD_LAST: begin
        // move last entry into the picked slot
        fr_we     = 1'b1;
        fr_wa     = pick_r[CW-1:0];
        fr_wd     = fr_rd_r;
        count_nxt = cnt_m1;
      end
      ST_MARK: begin
        mk_we = 1'b1;
        mk_wa = {row_r, col_r};
        mk_wd = MK_IN_MAZE;
        k_nxt = DIR_UP;
      end
      ST_NBR_RD: begin
        mk_re = nb_ok;
        if (!nb_ok) k_nxt = k_r + 1'b1;
      end
      ST_NBR_WR: begin
        if (mk_rd_r[1]) begin
          carved_nxt = 1'b1;
          dir_nxt    = k_r;
        end else if (!mk_rd_r[0]) begin
          // push fresh neighbour, mark visited
          mk_we = 1'b1;
          mk_wa = {nb_row, nb_col};
          mk_wd = MK_VISITED;
          if (count_r < NW'(NCELLS)) begin
            fr_we     = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        k_nxt = k_r + 1'b1;
      end
      ST_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    pick_r   <= pick_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    carved_r <= carved_nxt;
    dir_r    <= dir_nxt;
    done_r   <= done_nxt;
    k_r      <= k_nxt;
    clr_r    <= clr_nxt;
  end

  // mark memory
  always_ff @(posedge clk) begin
    if (mk_we) mk_mem[mk_wa] <= mk_wd;
    if (mk_re) mk_rd_r <= mk_mem[mk_ra];
  end

  // frontier memory
  always_ff @(posedge clk) begin
    if (fr_we) fr_mem[fr_wa] <= fr_wd;
    if (fr_re) fr_rd_r <= fr_mem[fr_ra];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
    if (state_r == ST_FIN && out_free) begin
      out_row_r    <= 6'(row_r);
      out_col_r    <= 6'(col_r);
      out_carved_r <= carved_r;
      out_dir_r    <= dir_r;
      out_left_r   <= 13'(count_r);
      out_done_r   <= done_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cell_row      = out_row_r;
  assign out_cell_col      = out_col_r;
  assign out_carved        = out_carved_r;
  assign out_carve_dir     = out_dir_r;
  assign out_frontier_left = out_left_r;
  assign out_maze_done     = out_done_r;

  `RPMG_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= NW'(NCELLS))
  `RPMG_ASSERT_IMP(a_mod_done_state, clk, rst_n, mod_st.done, state_r == ST_MOD)
  `RPMG_ASSERT_NXT(a_empty_step, clk, rst_n,
    in_xfer && in_req_type == REQ_STEP && count_r == '0, state_r == ST_FIN)
  `RPMG_ASSERT_NXT(a_fin_post, clk, rst_n,
    state_r == ST_FIN && out_free, out_valid_r && state_r == ST_IDLE)

endmodule
`default_nettype wire

// ===== tb/randomized_prim_maze_generator_tb.sv =====
// Self-checking testbench for the randomized Prim maze carver.
// Depends on rpmg_pkg and randomized_prim_maze_generator; drives a directed table then
// random start/step sequences, checking each result against its table entry or an in-bench carver.
`timescale 1ns / 1ps
module randomized_prim_maze_generator_tb;
  import rpmg_pkg::*;

  localparam int NROW = 64;
  localparam int NCOL = 64;
  localparam int NCELL = NROW * NCOL;
  localparam int LIMIT = 10000000;

  typedef struct packed {
    logic [5:0]  row;
    logic [5:0]  col;
    logic        carved;
    logic [1:0]  dir;
    logic [12:0] left;
    logic        done;
  } cell_result_t;

  typedef struct {
    logic        req;
    logic [31:0] rword;
    logic        known;
    cell_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_req_type = REQ_START;
  logic [31:0] in_random_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] out_cell_row;
  logic [5:0] out_cell_col;
  logic out_carved;
  logic [1:0] out_carve_dir;
  logic [12:0] out_frontier_left;
  logic out_maze_done;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_ROWS;
  logic [6:0] cfg_wdata = '0;

  randomized_prim_maze_generator DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // carver state mirrored in the bench
  logic [6:0] rows_reg = 7'd64;
  logic [6:0] cols_reg = 7'd64;
  bit in_maze [NCELL];
  bit visited [NCELL];
  int frontier [NCELL];
  int fr_count = 0;

  cell_result_t pending_q[$];
  bit failed = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int cycles = 0;

  function automatic int dim_of(logic [6:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic bit nbr(int r, int c, int k, output int nr, output int nc);
    int dr[4] = '{-1, 1, 0, 0};
    int dc[4] = '{0, 0, -1, 1};
    nr = r + dr[k];
    nc = c + dc[k];
    return nr >= 0 && nc >= 0 && nr < dim_of(rows_reg, NROW) && nc < dim_of(cols_reg, NCOL);
  endfunction

  function automatic void push_nbrs(int r, int c);
    int nr, nc, idx;
    for (int k = 0; k < 4; k++) begin
      if (!nbr(r, c, k, nr, nc)) continue;
      idx = nr * NCOL + nc;
      if (in_maze[idx] || visited[idx]) continue;
      if (fr_count < NCELL) begin
        frontier[fr_count] = idx;
        fr_count++;
      end
      visited[idx] = 1'b1;
    end
  endfunction

  // compute the cell an item adds and update the mirrored maze
  function automatic cell_result_t carve_cell(logic req, logic [31:0] rword);
    cell_result_t res;
    int pick, idx, r, c, nr, nc;
    res = '{6'd0, 6'd0, 1'b0, DIR_UP, 13'd0, 1'b0};
    if (req == REQ_START) begin
      for (int i = 0; i < NCELL; i++) begin
        in_maze[i] = 1'b0;
        visited[i] = 1'b0;
      end
      fr_count = 0;
      in_maze[0] = 1'b1;
      visited[0] = 1'b1;
      push_nbrs(0, 0);
      res.left = 13'(fr_count);
      return res;
    end
    if (fr_count == 0) begin
      res.done = 1'b1;
      return res;
    end
    pick = int'(rword % 32'(fr_count));
    idx = frontier[pick];
    fr_count--;
    frontier[pick] = frontier[fr_count];
    r = idx / NCOL;
    c = idx % NCOL;
    for (int k = 0; k < 4; k++) begin
      if (nbr(r, c, k, nr, nc) && in_maze[nr * NCOL + nc]) begin
        res.carved = 1'b1;
        res.dir = 2'(k);
      end
    end
    in_maze[idx] = 1'b1;
    push_nbrs(r, c);
    res.row = 6'(r);
    res.col = 6'(c);
    res.left = 13'(fr_count);
    return res;
  endfunction

  // drive one item and hold until its transfer; typed results take precedence
  task automatic send_item(logic req, logic [31:0] rword, bit known, cell_result_t want);
    cell_result_t got;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_random_word <= rword;
    do @(posedge clk); while (in_stall);
    got = carve_cell(req, rword);
    pending_q.push_back(known ? want : got);
  endtask

  // write both grid registers back to back
  task automatic write_grid(logic [6:0] rv, logic [6:0] cv);
    cfg_we <= 1'b1;
    cfg_index <= REG_ROWS;
    cfg_wdata <= rv;
    @(posedge clk);
    cfg_index <= REG_COLS;
    cfg_wdata <= cv;
    @(posedge clk);
    cfg_we <= 1'b0;
    rows_reg = rv;
    cols_reg = cv;
  endtask

  // drop the input, wait for all results, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (6000) @(posedge clk);
  endtask

  // random run: mostly a start then steps, with occasional early restarts
  task automatic random_run(int n_items);
    int n;
    n = 0;
    while (n < n_items) begin
      if (n == 0 || $urandom_range(99) < 3)
        send_item(REQ_START, $urandom, 1'b0, '{default: '0});
      else
        send_item(REQ_STEP, $urandom, 1'b0, '{default: '0});
      n++;
    end
  endtask

  // receiver stall and check
  always @(posedge clk) begin
    cell_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result row=%0d col=%0d", $time, out_cell_row, out_cell_col);
        failed = 1'b1;
      end else begin
        want = pending_q.pop_front();
        if (out_cell_row !== want.row || out_cell_col !== want.col ||
            out_carved !== want.carved || out_carve_dir !== want.dir ||
            out_frontier_left !== want.left || out_maze_done !== want.done) begin
          $display("%0t: mismatch expected r%0d c%0d cv%0d d%0d l%0d dn%0d", $time,
                   want.row, want.col, want.carved, want.dir, want.left, want.done);
          $display("%0t:          actual r%0d c%0d cv%0d d%0d l%0d dn%0d", $time,
                   out_cell_row, out_cell_col, out_carved, out_carve_dir,
                   out_frontier_left, out_maze_done);
          failed = 1'b1;
        end
      end
    end
    out_stall <= hold_off || (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // long receiver hold-off, past the start sweep, while items keep coming
  task automatic hold_receiver();
    hold_off = 1'b1;
    repeat (6000) @(posedge clk);
    hold_off = 1'b0;
  endtask

  stim_row_t dir_tab[$];
  localparam cell_result_t DONE_RES = '{6'd0, 6'd0, 1'b0, DIR_UP, 13'd0, 1'b1};
  localparam cell_result_t START_RES2 = '{6'd0, 6'd0, 1'b0, DIR_UP, 13'd2, 1'b0};

  initial begin
    // empty frontier after reset, start, then steps at word extremes
    dir_tab = '{
      '{REQ_STEP, 32'h0, 1'b1, DONE_RES},
      '{REQ_STEP, 32'hFFFF_FFFF, 1'b1, DONE_RES},
      '{REQ_START, 32'hFFFF_FFFF, 1'b1, START_RES2},
      '{REQ_STEP, 32'h0, 1'b0, DONE_RES},
      '{REQ_STEP, 32'hFFFF_FFFF, 1'b0, DONE_RES},
      '{REQ_STEP, 32'hAAAA_AAAA, 1'b0, DONE_RES},
      '{REQ_STEP, 32'h5555_5555, 1'b0, DONE_RES},
      '{REQ_STEP, 32'h8000_0000, 1'b0, DONE_RES},
      '{REQ_STEP, 32'h0000_0001, 1'b0, DONE_RES},
      '{REQ_START, 32'h0, 1'b1, START_RES2}
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i]) send_item(dir_tab[i].req, dir_tab[i].rword, dir_tab[i].known,
                                   dir_tab[i].res);
    drain();

    // 1x1 grid (zero saturates to one): start then an empty step
    write_grid(7'd0, 7'd0);
    send_item(REQ_START, 32'd7, 1'b0, '{default: '0});
    send_item(REQ_STEP, 32'd7, 1'b0, '{default: '0});
    drain();

    // small grid to completion, no idling
    write_grid(7'd3, 7'd4);
    random_run(20);
    drain();

    // oversize values saturate; sender idles, receiver held off
    write_grid(7'd127, 7'd65);
    send_idle_pct = 65;
    fork
      random_run(40);
      hold_receiver();
    join
    drain();

    // grid resized mid-maze (fewer rows, more columns) before further steps
    write_grid(7'd5, 7'd1);
    send_idle_pct = 0;
    recv_stall_pct = 65;
    random_run(60);
    drain();
    write_grid(7'd2, 7'd6);
    send_item(REQ_STEP, $urandom, 1'b0, '{default: '0});
    send_item(REQ_STEP, $urandom, 1'b0, '{default: '0});
    drain();

    // remaining random phases across sizes
    for (int ph = 0; ph < 6; ph++) begin
      write_grid(7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)));
      send_idle_pct = (ph % 3 == 0) ? 16 : (ph % 3 == 1 ? 65 : 0);
      recv_stall_pct = (ph % 3 == 0) ? 16 : (ph % 3 == 1 ? 0 : 65);
      random_run(70);
      drain();
    end
    write_grid(7'd64, 7'd64);
    random_run(30);
    drain();

    if (!failed && pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rpmg_pkg.sv
hw/rtl/rpmg_mod.sv
hw/rtl/randomized_prim_maze_generator.sv
tb/randomized_prim_maze_generator_tb.sv
